// ===== src/krt_pkg.sv =====
// shared constants, codes and record types for the keyed record table
// no dependencies
`default_nettype none

package krt_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W    = 32;
  localparam int VAL_W    = 16;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;
  localparam int ENTRY_W  = 9;
  localparam int CMP_W    = 15;
  localparam int REC_W    = KEY_W + VAL_W;

  localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SORT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } rec_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
    logic [SLOT_W-1:0]   slot;
    logic [ENTRY_W-1:0]  entries;
    logic [CMP_W-1:0]    comparisons;
  } result_t;

  // saturating comparison count helpers
  function automatic logic [CMP_W-1:0] cmp_inc(input logic [CMP_W-1:0] c);
    cmp_inc = (c == CMP_MAX) ? CMP_MAX : c + 1'b1;
  endfunction

  function automatic logic [CMP_W-1:0] cmp_of(input logic [CNT_W:0] n);
    logic [CNT_W+CMP_W:0] wide;
    wide = (CNT_W + CMP_W + 1)'(n);
    cmp_of = (wide > (CNT_W + CMP_W + 1)'(CMP_MAX)) ? CMP_MAX : CMP_W'(wide);
  endfunction

endpackage

`default_nettype wire

// ===== src/keyed_record_table.sv =====
// Fixed-capacity key/value table held in one record ram (key and value side by side,
// one read and one write per cycle, registered read). A request is taken only when the
// sequencer is idle; each request gives one result, held in an output register so the
// next request can be taken while the result waits. Add, remove, modify and find search
// by a linear scan, or by a binary search once the table is sorted; sort is an insertion
// sort over the records. Clear and invalid requests finish without a ram access. No
// clearing pass at reset.
// depends on krt_pkg, krt_ram, krt_ctrl
`default_nettype none

module keyed_record_table (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [krt_pkg::KIND_W-1:0]   kind,
  input  wire logic [krt_pkg::KEY_W-1:0]    key,
  input  wire logic [krt_pkg::VAL_W-1:0]    value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [krt_pkg::STATUS_W-1:0]      status,
  output logic [krt_pkg::VAL_W-1:0]         found_value,
  output logic [krt_pkg::SLOT_W-1:0]        slot,
  output logic [krt_pkg::ENTRY_W-1:0]       entries,
  output logic [krt_pkg::CMP_W-1:0]         comparisons
);

  import krt_pkg::*;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  rec_t              ram_wdata;
  rec_t              ram_rdata;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  result_t           out_r;

  krt_ram #(
    .WIDTH(REC_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .key      (key),
    .value    (value),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  // output register frees the sequencer once a result is parked
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign status      = out_r.status;
  assign found_value = out_r.found_value;
  assign slot        = out_r.slot;
  assign entries     = out_r.entries;
  assign comparisons = out_r.comparisons;

endmodule

`default_nettype wire

// ===== src/krt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/krt_ctrl.sv =====
// sequencer: search, update, clear and insertion sort over the record ram
// depends on krt_pkg
`default_nettype none

module krt_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [krt_pkg::KIND_W-1:0] kind,
  input  wire logic [krt_pkg::KEY_W-1:0]  key,
  input  wire logic [krt_pkg::VAL_W-1:0]  value,
  output logic                           ram_we,
  output logic [krt_pkg::ADDR_W-1:0]     ram_waddr,
  output krt_pkg::rec_t                  ram_wdata,
  output logic [krt_pkg::ADDR_W-1:0]     ram_raddr,
  input  krt_pkg::rec_t                  ram_rdata,
  output logic                           res_valid,
  input  wire logic                      res_take,
  output krt_pkg::result_t               res
);

  import krt_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_DEC  = 14'b00000000000010,
    S_LRD  = 14'b00000000000100,
    S_LEV  = 14'b00000000001000,
    S_BRD  = 14'b00000000010000,
    S_BEV  = 14'b00000000100000,
    S_ACT  = 14'b00000001000000,
    S_RMOV = 14'b00000010000000,
    S_SRDI = 14'b00000100000000,
    S_SLDI = 14'b00001000000000,
    S_SRDJ = 14'b00010000000000,
    S_SCMP = 14'b00100000000000,
    S_SPUT = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  state_t state;

  logic [KIND_W-1:0]   kind_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    val_r;
  logic [CNT_W-1:0]    count;
  logic                sorted;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    hip1;
  logic [ADDR_W-1:0]   mid;
  logic [CNT_W-1:0]    jp1;
  logic [ADDR_W-1:0]   pos;
  logic                found;
  rec_t                tmp;
  logic [VAL_W-1:0]    fval;
  logic [CMP_W-1:0]    cmps;
  logic [STATUS_W-1:0] status_r;
  logic [CNT_W-1:0]    mid_next;
  logic                full;

  // hip1 is one past the upper bound, so the window is empty when lo >= hip1
  assign mid_next = lo + ((hip1 - CNT_W'(1) - lo) >> 1);
  assign full     = (count == CNT_W'(CAPACITY));
  assign in_stall = (state != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_LRD:  ram_raddr = idx[ADDR_W-1:0];
      S_BRD:  ram_raddr = mid_next[ADDR_W-1:0];
      S_SRDI: ram_raddr = idx[ADDR_W-1:0];
      S_SRDJ: ram_raddr = ADDR_W'(jp1 - CNT_W'(1));
      S_ACT: begin
        if (kind_r == KIND_ADD && !found && !full) begin
          ram_we    = 1'b1;
          ram_waddr = count[ADDR_W-1:0];
          ram_wdata = '{key: key_r, value: val_r};
        end else if (kind_r == KIND_MODIFY && found) begin
          ram_we    = 1'b1;
          ram_waddr = pos;
          ram_wdata = '{key: key_r, value: val_r};
        end else if (kind_r == KIND_REMOVE && found) begin
          ram_raddr = ADDR_W'(count - CNT_W'(1));
        end
      end
      S_RMOV: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = ram_rdata;
      end
      S_SCMP: begin
        if (ram_rdata.key > tmp.key) begin
          ram_we    = 1'b1;
          ram_waddr = jp1[ADDR_W-1:0];
          ram_wdata = ram_rdata;
        end
      end
      S_SPUT: begin
        ram_we    = 1'b1;
        ram_waddr = jp1[ADDR_W-1:0];
        ram_wdata = tmp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      sorted <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= kind;
            key_r  <= key;
            val_r  <= value;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          cmps  <= '0;
          lo    <= '0;
          hip1  <= count;
          found <= 1'b0;
          pos   <= '0;
          case (kind_r)
            KIND_ADD, KIND_MODIFY: begin
              if (key_r == '0 || val_r == '0) begin
                status_r <= ST_INVALID;
                state    <= S_DONE;
              end else begin
                status_r <= ST_OK;
                idx      <= '0;
                state    <= sorted ? S_BRD : S_LRD;
              end
            end
            KIND_REMOVE, KIND_FIND: begin
              if (key_r == '0) begin
                status_r <= ST_INVALID;
                state    <= S_DONE;
              end else begin
                status_r <= ST_OK;
                idx      <= '0;
                state    <= sorted ? S_BRD : S_LRD;
              end
            end
            KIND_SORT: begin
              status_r <= ST_OK;
              if (count < CNT_W'(2)) begin
                sorted <= 1'b1;
                state  <= S_DONE;
              end else begin
                idx   <= CNT_W'(1);
                state <= S_SRDI;
              end
            end
            KIND_CLEAR: begin
              status_r <= ST_OK;
              count    <= '0;
              sorted   <= 1'b0;
              state    <= S_DONE;
            end
            default: begin
              status_r <= ST_INVALID;
              state    <= S_DONE;
            end
          endcase
        end
        S_LRD: begin
          if (idx == count) begin
            cmps  <= cmp_of({1'b0, count});
            state <= S_ACT;
          end else begin
            state <= S_LEV;
          end
        end
        S_LEV: begin
          if (ram_rdata.key == key_r) begin
            found <= 1'b1;
            pos   <= idx[ADDR_W-1:0];
            fval  <= ram_rdata.value;
            cmps  <= cmp_of({1'b0, idx} + (CNT_W + 1)'(1));
            state <= S_ACT;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_LRD;
          end
        end
        S_BRD: begin
          if (lo >= hip1) begin
            state <= S_ACT;
          end else begin
            mid   <= mid_next[ADDR_W-1:0];
            state <= S_BEV;
          end
        end
        S_BEV: begin
          if (ram_rdata.key == key_r) begin
            cmps  <= cmp_inc(cmps);
            found <= 1'b1;
            pos   <= mid;
            fval  <= ram_rdata.value;
            state <= S_ACT;
          end else begin
            cmps <= cmp_inc(cmp_inc(cmps));
            if (ram_rdata.key < key_r) begin
              lo <= CNT_W'(mid) + CNT_W'(1);
            end else begin
              hip1 <= CNT_W'(mid);
            end
            state <= S_BRD;
          end
        end
        S_ACT: begin
          case (kind_r)
            KIND_ADD: begin
              state <= S_DONE;
              if (found) begin
                status_r <= ST_DUPLICATE;
              end else if (full) begin
                status_r <= ST_FULL;
              end else begin
                count  <= count + CNT_W'(1);
                sorted <= 1'b0;
              end
            end
            KIND_REMOVE: begin
              if (!found) begin
                status_r <= ST_NOT_FOUND;
                state    <= S_DONE;
              end else begin
                state <= S_RMOV;
              end
            end
            default: begin
              state <= S_DONE;
              if (!found) begin
                status_r <= ST_NOT_FOUND;
              end
            end
          endcase
        end
        S_RMOV: begin
          count  <= count - CNT_W'(1);
          sorted <= 1'b0;
          state  <= S_DONE;
        end
        S_SRDI: state <= S_SLDI;
        S_SLDI: begin
          tmp   <= ram_rdata;
          jp1   <= idx;
          state <= S_SRDJ;
        end
        S_SRDJ: begin
          state <= (jp1 == '0) ? S_SPUT : S_SCMP;
        end
        S_SCMP: begin
          cmps <= cmp_inc(cmps);
          if (ram_rdata.key > tmp.key) begin
            jp1   <= jp1 - CNT_W'(1);
            state <= S_SRDJ;
          end else begin
            state <= S_SPUT;
          end
        end
        S_SPUT: begin
          if (idx + CNT_W'(1) == count) begin
            sorted <= 1'b1;
            state  <= S_DONE;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_SRDI;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic show_find;
  assign show_find = (kind_r == KIND_FIND) && (status_r == ST_OK);

  assign res_valid       = (state == S_DONE);
  assign res.status      = status_r;
  assign res.found_value = show_find ? fval : '0;
  assign res.slot        = show_find ? SLOT_W'(pos) : '0;
  assign res.entries     = ENTRY_W'(count);
  assign res.comparisons = (kind_r == KIND_FIND || kind_r == KIND_SORT) ? cmps : '0;

endmodule

`default_nettype wire

// ===== src/krt_check.sv =====
// port level checks for the keyed record table, bound to the top level
// depends on krt_pkg and keyed_record_table
`default_nettype none

module krt_check (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [krt_pkg::KIND_W-1:0]   kind,
  input wire logic [krt_pkg::KEY_W-1:0]    key,
  input wire logic [krt_pkg::VAL_W-1:0]    value,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [krt_pkg::STATUS_W-1:0] status,
  input wire logic [krt_pkg::VAL_W-1:0]    found_value,
  input wire logic [krt_pkg::SLOT_W-1:0]   slot,
  input wire logic [krt_pkg::ENTRY_W-1:0]  entries,
  input wire logic [krt_pkg::CMP_W-1:0]    comparisons
);

  import krt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entries))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken while one is in work");

  a_no_find_data_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> found_value == '0 && slot == '0)
    else $error("find data shown on a failed request");

  a_entries_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entries <= ENTRY_W'(CAPACITY))
    else $error("entry count above capacity");

  a_invalid_no_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_INVALID |-> comparisons == '0)
    else $error("comparisons counted on invalid request");

endmodule

bind keyed_record_table krt_check u_krt_check (.*);

`default_nettype wire
